// ===== sv/pca_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes and channel arithmetic for pixel_color_adjust.
// No dependencies; used by the top level and its checker.
package pca_pkg;

    localparam int CHAN_W   = 8;
    localparam int BRIGHT_W = 9;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 16;
    localparam int LUMA_W   = 24;

    typedef enum logic [1:0] {
        MODE_ROTATE   = 2'd0,
        MODE_BRIGHT   = 2'd1,
        MODE_CONTRAST = 2'd2,
        MODE_GRAY     = 2'd3
    } mode_t;

    typedef enum logic {
        REG_BRIGHTNESS = 1'b0,
        REG_CONTRAST   = 1'b1
    } reg_index_t;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'sd0;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;

    localparam logic [15:0] LUMA_WEIGHT_R = 16'd19661;
    localparam logic [15:0] LUMA_WEIGHT_G = 16'd38666;
    localparam logic [15:0] LUMA_WEIGHT_B = 16'd7209;

    localparam logic signed [25:0] CONTRAST_BIAS = 26'sd65280;
    localparam logic signed [25:0] CONTRAST_TOP  = 26'sd130560;

    function automatic logic [CHAN_W-1:0] bright_channel(
        input logic [CHAN_W-1:0]   c,
        input logic [BRIGHT_W-1:0] off
    );
        logic [9:0] sum;
        logic [CHAN_W-1:0] res;
        sum = {2'b00, c} + {off[BRIGHT_W-1], off};
        if (sum[9]) begin
            res = '0;
        end else if (sum[8]) begin
            res = '1;
        end else begin
            res = sum[7:0];
        end
        return res;
    endfunction

    function automatic logic [CHAN_W-1:0] contrast_channel(
        input logic [CHAN_W-1:0] c,
        input logic [GAIN_W-1:0] gain
    );
        logic signed [8:0]  diff;
        logic signed [16:0] gain_s;
        logic signed [25:0] v;
        logic [CHAN_W-1:0]  res;
        diff   = $signed({c, 1'b0}) - 9'sd255;
        gain_s = $signed({1'b0, gain});
        v      = 26'(diff * gain_s) + CONTRAST_BIAS;
        if (v < 0) begin
            res = '0;
        end else if (v >= CONTRAST_TOP) begin
            res = '1;
        end else begin
            res = v[16:9];
        end
        return res;
    endfunction

endpackage

// ===== sv/pixel_color_adjust.sv =====
`timescale 1ns / 1ps
// Top level of the per-pixel RGB point-operation unit.
// Depends on pca_pkg for mode codes, register indexes and channel arithmetic.

// One pixel is accepted on every clock at which start is high; busy is never
// asserted, so items may be issued back to back at one per clock. Each item
// yields exactly one result: the pixel is taken into an input register, the
// selected point operation runs in one pass of logic (three 9x17 multipliers
// for contrast, three 8x16 for luma), and the result register drives done for
// one cycle with the adjusted pixel. The receiver cannot stall, so every
// result must be taken when done is high. Configuration writes take effect on
// the next clock and are meant to be made while no item is in flight.
module pixel_color_adjust (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  mode,
    input  logic [pca_pkg::CHAN_W-1:0]  red_in,
    input  logic [pca_pkg::CHAN_W-1:0]  green_in,
    input  logic [pca_pkg::CHAN_W-1:0]  blue_in,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [pca_pkg::CFG_W-1:0]   cfg_data,
    output logic                        done,
    output logic [pca_pkg::CHAN_W-1:0]  red_out,
    output logic [pca_pkg::CHAN_W-1:0]  green_out,
    output logic [pca_pkg::CHAN_W-1:0]  blue_out,
    output logic                        rejected
);

    logic [pca_pkg::BRIGHT_W-1:0] bright_reg;
    logic [pca_pkg::GAIN_W-1:0]   gain_reg;

    logic                        valid_reg;
    pca_pkg::mode_t              mode_reg;
    logic [pca_pkg::CHAN_W-1:0]  r_reg;
    logic [pca_pkg::CHAN_W-1:0]  g_reg;
    logic [pca_pkg::CHAN_W-1:0]  b_reg;

    logic                        done_reg;
    logic [pca_pkg::CHAN_W-1:0]  r_out_reg;
    logic [pca_pkg::CHAN_W-1:0]  g_out_reg;
    logic [pca_pkg::CHAN_W-1:0]  b_out_reg;
    logic                        rej_reg;

    logic [pca_pkg::CHAN_W-1:0]  r_next;
    logic [pca_pkg::CHAN_W-1:0]  g_next;
    logic [pca_pkg::CHAN_W-1:0]  b_next;
    logic                        rej_next;
    logic [pca_pkg::LUMA_W-1:0]  luma_sum;

    function automatic logic [pca_pkg::LUMA_W-1:0] LUMA_WEIGHT_MAC(
        input logic [pca_pkg::CHAN_W-1:0] r,
        input logic [pca_pkg::CHAN_W-1:0] g,
        input logic [pca_pkg::CHAN_W-1:0] b
    );
        logic [pca_pkg::LUMA_W-1:0] pr;
        logic [pca_pkg::LUMA_W-1:0] pg;
        logic [pca_pkg::LUMA_W-1:0] pb;
        pr = r * pca_pkg::LUMA_WEIGHT_R;
        pg = g * pca_pkg::LUMA_WEIGHT_G;
        pb = b * pca_pkg::LUMA_WEIGHT_B;
        return pr + pg + pb;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= pca_pkg::BRIGHT_RESET;
            gain_reg   <= pca_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (pca_pkg::reg_index_t'(cfg_index))
                pca_pkg::REG_BRIGHTNESS: bright_reg <= cfg_data[pca_pkg::BRIGHT_W-1:0];
                pca_pkg::REG_CONTRAST:   gain_reg   <= cfg_data[pca_pkg::GAIN_W-1:0];
                default:                 gain_reg   <= gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= pca_pkg::mode_t'(mode);
            r_reg    <= red_in;
            g_reg    <= green_in;
            b_reg    <= blue_in;
        end
        if (valid_reg)
        begin
            r_out_reg <= r_next;
            g_out_reg <= g_next;
            b_out_reg <= b_next;
            rej_reg   <= rej_next;
        end
    end

    assign luma_sum = LUMA_WEIGHT_MAC(r_reg, g_reg, b_reg);

    always_comb
    begin
        r_next   = r_reg;
        g_next   = g_reg;
        b_next   = b_reg;
        rej_next = 1'b0;
        case (mode_reg)
            pca_pkg::MODE_ROTATE:
            begin
                r_next = g_reg;
                g_next = b_reg;
                b_next = r_reg;
            end
            pca_pkg::MODE_BRIGHT:
            begin
                r_next = pca_pkg::bright_channel(r_reg, bright_reg);
                g_next = pca_pkg::bright_channel(g_reg, bright_reg);
                b_next = pca_pkg::bright_channel(b_reg, bright_reg);
            end
            pca_pkg::MODE_CONTRAST:
            begin
                if (gain_reg == '0)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    r_next = pca_pkg::contrast_channel(r_reg, gain_reg);
                    g_next = pca_pkg::contrast_channel(g_reg, gain_reg);
                    b_next = pca_pkg::contrast_channel(b_reg, gain_reg);
                end
            end
            pca_pkg::MODE_GRAY:
            begin
                r_next = luma_sum[pca_pkg::LUMA_W-1 -: pca_pkg::CHAN_W];
                g_next = luma_sum[pca_pkg::LUMA_W-1 -: pca_pkg::CHAN_W];
                b_next = luma_sum[pca_pkg::LUMA_W-1 -: pca_pkg::CHAN_W];
            end
            default:
            begin
                rej_next = 1'b0;
            end
        endcase
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign red_out   = r_out_reg;
    assign green_out = g_out_reg;
    assign blue_out  = b_out_reg;
    assign rejected  = done_reg & rej_reg;

endmodule

// ===== sv/pca_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for pixel_color_adjust, attached by the bind at the end.
// Depends on pca_pkg for the mode codes.
module pca_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  mode,
    input logic [pca_pkg::CHAN_W-1:0]  red_in,
    input logic [pca_pkg::CHAN_W-1:0]  green_in,
    input logic [pca_pkg::CHAN_W-1:0]  blue_in,
    input logic                        done,
    input logic [pca_pkg::CHAN_W-1:0]  red_out,
    input logic [pca_pkg::CHAN_W-1:0]  green_out,
    input logic [pca_pkg::CHAN_W-1:0]  blue_out,
    input logic                        rejected
);

    // Every accepted item produces its result, signalled by done.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("item accepted without a result two cycles later");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result strobe without a matching item");

    assert property (@(posedge clk) disable iff (!rst_n)
        rejected |-> done)
        else $error("rejected flag raised outside a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && mode == pca_pkg::MODE_ROTATE |=> ##1
            (red_out == $past(green_in, 2) && green_out == $past(blue_in, 2)
             && blue_out == $past(red_in, 2)))
        else $error("channel rotation result is wrong");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && mode == pca_pkg::MODE_GRAY |=> ##1
            (red_out == green_out && green_out == blue_out && !rejected))
        else $error("grayscale result has unequal channels");

endmodule

bind pixel_color_adjust pca_checker u_pca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .done      (done),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .rejected  (rejected)
);
